FILE: rtl/crcme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC engine package
// Mode codes, polynomials, the item type and the byte fold functions.
// ----------------------------------------------------------------------------
package crcme_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned HALF_W = 16;

    localparam logic [CRC_W-1:0] POLY_REFL32 = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] POLY_ARC16  = 32'h0000_A001;
    localparam logic [CRC_W-1:0] POLY_MPEG32 = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] LOW_MASK    = 32'h0000_FFFF;

    typedef enum logic [1:0] {
        MODE_CRC32 = 2'd0,
        MODE_ARC16 = 2'd1,
        MODE_MPEG2 = 2'd2
    } crc_mode_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              first;
        logic              last;
    } crcme_item_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] check;
    } crcme_fold_t;

    function automatic logic [CRC_W-1:0] fold_reflected(
        input logic [CRC_W-1:0]  c_in,
        input logic [DATA_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = c_in ^ {{(CRC_W-DATA_W){1'b0}}, b};
        for (int k = 0; k < DATA_W; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] fold_msb_first(
        input logic [CRC_W-1:0]  c_in,
        input logic [DATA_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = c_in ^ {b, {(CRC_W-DATA_W){1'b0}}};
        for (int k = 0; k < DATA_W; k++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ POLY_MPEG32) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/crcme_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC byte fold
// Folds one byte into the running CRC for the selected mode and forms the
// finished check value.
// ----------------------------------------------------------------------------
module crcme_fold (
    input  crcme_pkg::crc_mode_t   mode,
    input  logic [31:0]            crc_in,
    input  crcme_pkg::crcme_item_t item,
    output crcme_pkg::crcme_fold_t fold
);
    import crcme_pkg::*;

    logic [CRC_W-1:0] start;
    logic [CRC_W-1:0] crc_new;

    always_comb begin
        if (item.first) begin
            start = (mode == MODE_ARC16) ? '0 : ALL_ONES;
        end else begin
            start = crc_in;
        end
        case (mode)
            MODE_ARC16: begin
                crc_new    = fold_reflected(start & LOW_MASK, item.data, POLY_ARC16) & LOW_MASK;
                fold.check = crc_new;
            end
            MODE_MPEG2: begin
                crc_new    = fold_msb_first(start, item.data);
                fold.check = crc_new;
            end
            default: begin
                crc_new    = fold_reflected(start, item.data, POLY_REFL32);
                fold.check = crc_new ^ ALL_ONES;
            end
        endcase
        fold.crc = crc_new;
    end

endmodule

FILE: rtl/multi_standard_crc_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-standard CRC engine
// Byte-stream CRC with reflected CRC-32, CRC-16/ARC and CRC-32/MPEG-2 modes.
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  data byte, first mark, last mark
// m_*       out        m_tvalid / m_tready  32-bit check value
// cfg_*     in         cfg_valid/cfg_ready  2-bit mode
//
// One byte is taken every clock unless a stalled last item holds the input;
// the whole fold runs between the input register and the CRC and result registers.
// A result that waits in the output register stalls only items marked last.
// Synchronous active-low reset clears the mode to reflected CRC-32 and the
// running CRC to all ones.
// ----------------------------------------------------------------------------
module multi_standard_crc_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] check_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    import crcme_pkg::*;

    crc_mode_t        mode_reg;
    crcme_item_t      item_reg;
    logic             item_valid_reg;
    logic [CRC_W-1:0] crc_reg;
    logic             out_valid_reg;
    logic [CRC_W-1:0] out_data_reg;
    crcme_fold_t      fold;
    logic             advance;

    assign advance   = item_valid_reg && (!item_reg.last || !out_valid_reg || m_tready);
    assign s_tready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    crcme_fold u_fold (
        .mode   (mode_reg),
        .crc_in (crc_reg),
        .item   (item_reg),
        .fold   (fold)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_CRC32;
            item_valid_reg <= 1'b0;
            crc_reg        <= ALL_ONES;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= crc_mode_t'(cfg_data);
            end
            if (s_tvalid && s_tready) begin
                item_valid_reg <= 1'b1;
                item_reg.data  <= s_tdata;
                item_reg.first <= s_tuser;
                item_reg.last  <= s_tlast;
            end else if (advance) begin
                item_valid_reg <= 1'b0;
            end
            if (advance) begin
                crc_reg <= fold.crc;
            end
            if (advance && item_reg.last) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= fold.check;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_arc16_high_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode_reg == MODE_ARC16) |=> crc_reg[CRC_W-1:HALF_W] == '0)
        else $error("CRC-16 fold left high bits set");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.last) |=> m_tvalid)
        else $error("Last item did not produce a result");

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_valid_reg |-> s_tready)
        else $error("Input refused with empty input register");

    a_nonlast_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !item_reg.last && !m_tvalid) |=> !m_tvalid)
        else $error("Result appeared without a last item");

endmodule
